// ===== rtl/cnfa_pkg.sv =====
// Shared types and constants for the contiguous next-fit allocator.
// Used by cnfa_seq and contiguous_next_fit_allocator_core; no dependencies.
package cnfa_pkg;

    // Store geometry.
    localparam int ROW_CELLS   = 32;
    localparam int ROWS        = 8;
    localparam int STORE_CELLS = ROW_CELLS * ROWS;
    localparam int ADDR_W      = $clog2(STORE_CELLS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int TAG_W       = 8;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_FIND  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_PACK  = 2'd2
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_OOM     = 2'd1,
        STAT_NOFIT   = 2'd2,
        STAT_ILLEGAL = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_ALLOC,
        ST_PACK,
        ST_FILL,
        ST_DONE
    } t_state;

    // One command as taken from the input channel.
    typedef struct packed {
        logic [7:0] owner;
        logic [8:0] run_length;
        logic [7:0] start_index;
        t_cmd       cmd;
    } t_item;

    // One result handed to the output register.
    typedef struct packed {
        logic       valid;
        logic [7:0] position;
        t_status    status;
    } t_result;

    // Access request to the cell store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [TAG_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== rtl/cnfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cnfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cnfa_seq.sv =====
// Command sequencer: walks the cell store through read-modify-write passes.
// Depends on cnfa_pkg; drives one cnfa_ram instance through a t_mem_req.
module cnfa_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  cnfa_pkg::t_item           i_item,
    input  logic                      i_out_free,
    output cnfa_pkg::t_result         o_result,
    output cnfa_pkg::t_mem_req        o_mem,
    input  logic [cnfa_pkg::TAG_W-1:0] i_mem_rdata
);

    cnfa_pkg::t_state  r_state;
    cnfa_pkg::t_state  n_state;

    logic [cnfa_pkg::ADDR_W-1:0] r_addr;
    logic [cnfa_pkg::CNT_W-1:0]  r_issue;
    logic                        r_pv;
    logic [cnfa_pkg::ADDR_W-1:0] r_pidx;
    logic [cnfa_pkg::CNT_W-1:0]  r_w;
    logic [cnfa_pkg::CNT_W-1:0]  r_run;
    logic [cnfa_pkg::CNT_W-1:0]  r_free;
    logic [7:0]                  r_start;
    logic [8:0]                  r_n;
    logic [cnfa_pkg::TAG_W-1:0]  r_tag;
    logic                        r_hit_ge;
    logic [7:0]                  r_pos_ge;
    logic                        r_hit_any;
    logic [7:0]                  r_pos_any;
    logic [7:0]                  r_pos;
    cnfa_pkg::t_status           r_status;

    logic                        w_accept;
    logic                        w_last;
    logic                        w_cell_free;
    logic [cnfa_pkg::CNT_W-1:0]  w_room;
    logic [cnfa_pkg::CNT_W-1:0]  w_alloc_cnt;
    logic                        w_oom;
    logic [cnfa_pkg::CNT_W-1:0]  w_run_new;
    logic                        w_hit;
    logic                        w_ge;
    logic [7:0]                  w_cand;
    logic                        w_ge_f;
    logic                        w_any_f;
    logic [7:0]                  w_pos_ge_f;
    logic [7:0]                  w_pos_any_f;
    logic [cnfa_pkg::CNT_W-1:0]  w_w_next;

    // Shared decode of the incoming command and of the returning read data.
    assign w_accept    = i_valid && (r_state == cnfa_pkg::ST_IDLE);
    assign w_last      = r_pv && (r_issue == '0);
    assign w_cell_free = (i_mem_rdata == '0);
    assign w_room      = cnfa_pkg::CNT_W'(cnfa_pkg::STORE_CELLS)
                         - cnfa_pkg::CNT_W'(i_item.start_index);
    assign w_alloc_cnt = (cnfa_pkg::CNT_W'(i_item.run_length) > w_room) ? w_room
                         : cnfa_pkg::CNT_W'(i_item.run_length);
    assign w_oom       = cnfa_pkg::CNT_W'(i_item.run_length) > r_free;

    // Free-run tracking for the find pass; a window ends at the cell in hand.
    assign w_run_new   = w_cell_free ? (r_run + 1'b1) : '0;
    assign w_hit       = r_pv && (w_run_new >= cnfa_pkg::CNT_W'(r_n));
    assign w_ge        = (10'(r_pidx) + 10'd1) >= (10'(r_start) + 10'(r_n));
    assign w_cand      = r_pidx + 8'd1 - r_n[7:0];
    assign w_ge_f      = r_hit_ge || (w_hit && w_ge);
    assign w_any_f     = r_hit_any || w_hit;
    assign w_pos_ge_f  = r_hit_ge ? r_pos_ge : w_cand;
    assign w_pos_any_f = r_hit_any ? r_pos_any : w_cand;

    // Compaction write pointer after the cell in hand.
    assign w_w_next    = r_w + cnfa_pkg::CNT_W'(!w_cell_free);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cnfa_pkg::ST_CLEAR: begin
                if (r_w == cnfa_pkg::CNT_W'(cnfa_pkg::STORE_CELLS - 1)) begin
                    n_state = cnfa_pkg::ST_IDLE;
                end
            end
            cnfa_pkg::ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.cmd)
                        cnfa_pkg::CMD_FIND: begin
                            if (w_oom || (i_item.run_length == '0)) begin
                                n_state = cnfa_pkg::ST_DONE;
                            end else begin
                                n_state = cnfa_pkg::ST_FIND;
                            end
                        end
                        cnfa_pkg::CMD_ALLOC: begin
                            if ((i_item.owner == '0) || (w_alloc_cnt == '0)) begin
                                n_state = cnfa_pkg::ST_DONE;
                            end else begin
                                n_state = cnfa_pkg::ST_ALLOC;
                            end
                        end
                        cnfa_pkg::CMD_PACK: n_state = cnfa_pkg::ST_PACK;
                        default:            n_state = cnfa_pkg::ST_DONE;
                    endcase
                end
            end
            cnfa_pkg::ST_FIND, cnfa_pkg::ST_ALLOC: begin
                if (w_last) begin
                    n_state = cnfa_pkg::ST_DONE;
                end
            end
            cnfa_pkg::ST_PACK: begin
                if (w_last) begin
                    if (w_w_next == cnfa_pkg::CNT_W'(cnfa_pkg::STORE_CELLS)) begin
                        n_state = cnfa_pkg::ST_DONE;
                    end else begin
                        n_state = cnfa_pkg::ST_FILL;
                    end
                end
            end
            cnfa_pkg::ST_FILL: begin
                if (r_w == cnfa_pkg::CNT_W'(cnfa_pkg::STORE_CELLS - 1)) begin
                    n_state = cnfa_pkg::ST_DONE;
                end
            end
            cnfa_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = cnfa_pkg::ST_IDLE;
                end
            end
            default: n_state = cnfa_pkg::ST_CLEAR;
        endcase
    end

    // Outputs: handshake, memory accesses and the result.
    always_comb begin
        o_ready         = (r_state == cnfa_pkg::ST_IDLE);
        o_mem           = '0;
        o_mem.raddr     = r_addr;
        o_result.valid    = (r_state == cnfa_pkg::ST_DONE) && i_out_free;
        o_result.position = r_pos;
        o_result.status   = r_status;
        unique case (r_state)
            cnfa_pkg::ST_CLEAR, cnfa_pkg::ST_FILL: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_w[cnfa_pkg::ADDR_W-1:0];
                o_mem.wdata = '0;
            end
            cnfa_pkg::ST_FIND: begin
                o_mem.re = (r_issue != '0);
            end
            cnfa_pkg::ST_ALLOC: begin
                o_mem.re    = (r_issue != '0);
                o_mem.we    = r_pv && w_cell_free;
                o_mem.waddr = r_pidx;
                o_mem.wdata = r_tag;
            end
            cnfa_pkg::ST_PACK: begin
                o_mem.re    = (r_issue != '0);
                o_mem.we    = r_pv && !w_cell_free;
                o_mem.waddr = r_w[cnfa_pkg::ADDR_W-1:0];
                o_mem.wdata = i_mem_rdata;
            end
            default: begin
                o_mem.re = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cnfa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: read pipeline, counters and the per-command bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= '0;
            r_free  <= cnfa_pkg::CNT_W'(cnfa_pkg::STORE_CELLS);
            r_pv    <= 1'b0;
            r_issue <= '0;
        end else begin
            r_pv   <= o_mem.re;
            r_pidx <= r_addr;
            if (o_mem.re) begin
                r_addr  <= r_addr + 1'b1;
                r_issue <= r_issue - 1'b1;
            end
            unique case (r_state)
                cnfa_pkg::ST_CLEAR, cnfa_pkg::ST_FILL: begin
                    r_w <= r_w + 1'b1;
                end
                cnfa_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_start   <= i_item.start_index;
                        r_n       <= i_item.run_length;
                        r_tag     <= i_item.owner;
                        r_run     <= '0;
                        r_hit_ge  <= 1'b0;
                        r_hit_any <= 1'b0;
                        r_w       <= '0;
                        r_pos     <= '0;
                        r_status  <= cnfa_pkg::STAT_OK;
                        r_addr    <= '0;
                        r_issue   <= cnfa_pkg::CNT_W'(cnfa_pkg::STORE_CELLS);
                        unique case (i_item.cmd)
                            cnfa_pkg::CMD_FIND: begin
                                if (w_oom) begin
                                    r_status <= cnfa_pkg::STAT_OOM;
                                end else if (i_item.run_length == '0) begin
                                    r_pos <= i_item.start_index;
                                end
                            end
                            cnfa_pkg::CMD_ALLOC: begin
                                r_addr  <= i_item.start_index;
                                r_issue <= w_alloc_cnt;
                                // A zero tag or a run past the end is illegal.
                                if ((i_item.owner == '0) ||
                                    (cnfa_pkg::CNT_W'(i_item.run_length) > w_room)) begin
                                    r_status <= cnfa_pkg::STAT_ILLEGAL;
                                end
                            end
                            default: begin
                                r_pos <= '0;
                            end
                        endcase
                    end
                end
                cnfa_pkg::ST_FIND: begin
                    if (r_pv) begin
                        r_run <= w_run_new;
                        if (w_hit && !r_hit_any) begin
                            r_hit_any <= 1'b1;
                            r_pos_any <= w_cand;
                        end
                        if (w_hit && w_ge && !r_hit_ge) begin
                            r_hit_ge <= 1'b1;
                            r_pos_ge <= w_cand;
                        end
                    end
                    // Prefer the first fit at or after the start, else wrap around.
                    if (w_last) begin
                        if (w_ge_f) begin
                            r_pos <= w_pos_ge_f;
                        end else if (w_any_f) begin
                            r_pos <= w_pos_any_f;
                        end else begin
                            r_status <= cnfa_pkg::STAT_NOFIT;
                        end
                    end
                end
                cnfa_pkg::ST_ALLOC: begin
                    if (r_pv) begin
                        if (w_cell_free) begin
                            if (r_free != '0) begin
                                r_free <= r_free - 1'b1;
                            end
                        end else begin
                            r_status <= cnfa_pkg::STAT_ILLEGAL;
                        end
                    end
                end
                cnfa_pkg::ST_PACK: begin
                    if (r_pv) begin
                        r_w <= w_w_next;
                    end
                end
                default: begin
                    r_run <= r_run;
                end
            endcase
        end
    end

endmodule

// ===== rtl/contiguous_next_fit_allocator_core.sv =====
// Find: one pass over all 256 cells through the store's read port; OOM,
// empty-run and unused commands skip the pass. Allocate: one read per run cell.
// Compact: a packing pass over the store plus one write per cleared cell. One
// command is worked at a time; the next is taken while a result waits in the
// output register. After reset a clearing pass zeroes all 256 cells of the
// store before the first command is accepted.
// Top level: stream ports, output register, cnfa_seq and cnfa_ram; uses cnfa_pkg.
module contiguous_next_fit_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [7:0] start_index, [16:8] run_length, [24:17] owner
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] position
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    cnfa_pkg::t_item     w_item;
    cnfa_pkg::t_result   w_result;
    cnfa_pkg::t_mem_req  w_mem;
    logic [cnfa_pkg::TAG_W-1:0] w_rdata;
    logic                w_out_free;

    logic                r_ovalid;
    logic [7:0]          r_opos;
    cnfa_pkg::t_status   r_ostat;

    // Unpack the input transaction.
    assign w_item.start_index = i_s_tdata[7:0];
    assign w_item.run_length  = i_s_tdata[16:8];
    assign w_item.owner       = i_s_tdata[24:17];
    assign w_item.cmd         = cnfa_pkg::t_cmd'(i_s_tuser);

    // The output register can take a result when empty or draining.
    assign w_out_free = !r_ovalid || i_m_tready;

    cnfa_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_item      (w_item),
        .i_out_free  (w_out_free),
        .o_result    (w_result),
        .o_mem       (w_mem),
        .i_mem_rdata (w_rdata)
    );

    cnfa_ram #(
        .WIDTH (cnfa_pkg::TAG_W),
        .DEPTH (cnfa_pkg::STORE_CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    // Output register holding one result transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_result.valid) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.valid) begin
            r_opos  <= w_result.position;
            r_ostat <= w_result.status;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_opos;
    assign o_m_tuser  = r_ostat;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for contiguous_next_fit_allocator_core: directed and random
// find, allocate and compact transactions, checked against a cell-level predictor.
// Depends on cnfa_pkg and the core's RTL only.
`timescale 1ns / 1ps

module testbench;

    // The command code that the core ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TOTAL_ITEMS = 400;
    localparam int DRAIN_CYCLES = 600;
    localparam int HOLD_CYCLES = 3000;

    // One expected result.
    typedef struct {
        logic [7:0]        position;
        cnfa_pkg::t_status status;
    } t_alloc_reply;

    // Tracks the cell store and free count and holds the replies still owed.
    class allocator_scoreboard;
        bit [7:0]     cells [cnfa_pkg::STORE_CELLS];
        int unsigned  free_count = cnfa_pkg::STORE_CELLS;
        t_alloc_reply owed_replies [$];
        int           errors = 0;

        // Circular next-fit search starting at the given cell.
        function cnfa_pkg::t_status first_fit(logic [7:0] from, logic [8:0] len,
                                              output logic [7:0] pos);
            int p;
            int k;
            bit clear;
            pos = '0;
            if (len > free_count) return cnfa_pkg::STAT_OOM;
            for (int t = 0; t < cnfa_pkg::STORE_CELLS; t++) begin
                p = (from + t) % cnfa_pkg::STORE_CELLS;
                if (len <= cnfa_pkg::STORE_CELLS - p) begin
                    clear = 1'b1;
                    for (k = 0; k < len && clear; k++)
                        if (cells[p + k] != 0) clear = 1'b0;
                    if (clear) begin
                        pos = p[7:0];
                        return cnfa_pkg::STAT_OK;
                    end
                end
            end
            return cnfa_pkg::STAT_NOFIT;
        endfunction

        // Applies one accepted command and queues the reply that it owes.
        function void note_command(logic [1:0] cmd, logic [7:0] start,
                                   logic [8:0] len, logic [7:0] owner);
            t_alloc_reply r;
            int c;
            int w;
            bit bad;
            r.position = '0;
            r.status   = cnfa_pkg::STAT_OK;
            case (cmd)
                cnfa_pkg::CMD_FIND: begin
                    r.status = first_fit(start, len, r.position);
                end
                cnfa_pkg::CMD_ALLOC: begin
                    if (owner == '0) begin
                        r.status = cnfa_pkg::STAT_ILLEGAL;
                    end else begin
                        bad = 1'b0;
                        for (c = start; c < start + len; c++) begin
                            if (c >= cnfa_pkg::STORE_CELLS) begin
                                bad = 1'b1;
                                break;
                            end
                            if (cells[c] == 0) begin
                                cells[c] = owner;
                                if (free_count > 0) free_count--;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        if (bad) r.status = cnfa_pkg::STAT_ILLEGAL;
                    end
                end
                cnfa_pkg::CMD_PACK: begin
                    // Occupied cells slide to the front in order.
                    w = 0;
                    for (c = 0; c < cnfa_pkg::STORE_CELLS; c++) begin
                        if (cells[c] != 0) begin
                            cells[w] = cells[c];
                            w++;
                        end
                    end
                    for (c = w; c < cnfa_pkg::STORE_CELLS; c++) cells[c] = '0;
                end
                default: ;
            endcase
            owed_replies.insert(owed_replies.size(), r);
        endfunction

        // Compares one accepted result with the oldest reply owed.
        function void check_result(logic [7:0] pos, logic [1:0] stat);
            t_alloc_reply r;
            if (owed_replies.size() == 0) begin
                $error("result with no command outstanding: position %0d, status %0d",
                       pos, stat);
                errors++;
                return;
            end
            r = owed_replies.pop_front();
            if (pos !== r.position) begin
                $error("position mismatch: expected %0d, actual %0d", r.position, pos);
                errors++;
            end
            if (stat !== r.status) begin
                $error("status mismatch: expected %0d, actual %0d", r.status, stat);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        o_m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic [1:0]  o_m_tuser;

    allocator_scoreboard sb;
    int  items_sent = 0;
    int  send_idle_pct = 36;
    int  recv_idle_pct = 51;
    bit  pressure_go = 1'b0;
    bit  pressure_done = 1'b0;
    int  hold_left = 0;
    int  cycle_count = 0;

    contiguous_next_fit_allocator_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: check each transaction, then pick tready for the next cycle.
    always @(posedge clk) begin
        if (rst_n) begin
            if (o_m_tvalid && m_tready) sb.check_result(o_m_tdata, o_m_tuser);
            if (pressure_go && !pressure_done) begin
                hold_left = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one command, with random gaps, and waits for its transaction.
    task automatic send_cmd(logic [1:0] cmd, logic [7:0] start, logic [8:0] len,
                            logic [7:0] owner);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, owner, len, start};
        @(posedge clk);
        while (!o_s_tready) @(posedge clk);
        sb.note_command(cmd, start, len, owner);
        items_sent++;
    endtask

    initial begin
        logic [7:0] from;
        logic [8:0] len;
        logic [7:0] pos;
        int pick;

        sb = new;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty runs, full-size runs, the ignored code, bad allocations,
        // no fit, out of memory, compaction and the wrap past the store's end.
        send_cmd(cnfa_pkg::CMD_FIND, 8'd255, 9'd0, 8'd0);
        send_cmd(cnfa_pkg::CMD_FIND, 8'd17, 9'd256, 8'd0);
        send_cmd(CMD_UNUSED, 8'd255, 9'd256, 8'd255);
        send_cmd(cnfa_pkg::CMD_ALLOC, 8'd0, 9'd0, 8'd5);
        send_cmd(cnfa_pkg::CMD_ALLOC, 8'd10, 9'd4, 8'd0);
        send_cmd(cnfa_pkg::CMD_ALLOC, 8'd250, 9'd10, 8'd255);
        send_cmd(cnfa_pkg::CMD_ALLOC, 8'd252, 9'd2, 8'd7);
        send_cmd(cnfa_pkg::CMD_ALLOC, 8'd0, 9'd8, 8'd1);
        send_cmd(cnfa_pkg::CMD_ALLOC, 8'd20, 9'd16, 8'd128);
        send_cmd(cnfa_pkg::CMD_FIND, 8'd5, 9'd8, 8'd0);
        send_cmd(cnfa_pkg::CMD_FIND, 8'd100, 9'd200, 8'd0);
        send_cmd(cnfa_pkg::CMD_FIND, 8'd0, 9'd220, 8'd0);
        send_cmd(cnfa_pkg::CMD_FIND, 8'd0, 9'd230, 8'd0);
        send_cmd(cnfa_pkg::CMD_PACK, 8'd0, 9'd0, 8'd0);
        send_cmd(cnfa_pkg::CMD_FIND, 8'd200, 9'd226, 8'd0);
        send_cmd(cnfa_pkg::CMD_FIND, 8'd29, 9'd1, 8'd0);
        send_cmd(cnfa_pkg::CMD_ALLOC, 8'd255, 9'd1, 8'h55);
        send_cmd(cnfa_pkg::CMD_PACK, 8'd0, 9'd0, 8'd0);
        send_cmd(cnfa_pkg::CMD_FIND, 8'd255, 9'd2, 8'd0);
        send_cmd(cnfa_pkg::CMD_ALLOC, 8'd128, 9'd1, 8'hAA);

        // Random: in half of the picks a find followed by an allocation at the fit it reports.
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= 280) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                pressure_go = 1'b1;
            end else if (items_sent >= 150) begin
                send_idle_pct = 51;
                recv_idle_pct = 36;
            end
            pick = $urandom_range(99);
            from = 8'($urandom_range(255));
            if (pick < 50) begin
                len = ($urandom_range(99) < 85) ? 9'($urandom_range(2, 1))
                                                : 9'($urandom_range(16, 3));
                send_cmd(cnfa_pkg::CMD_FIND, from, len, 8'($urandom_range(255)));
                if (sb.first_fit(from, len, pos) == cnfa_pkg::STAT_OK)
                    send_cmd(cnfa_pkg::CMD_ALLOC, pos, len, 8'($urandom_range(255, 1)));
            end else if (pick < 65) begin
                send_cmd(cnfa_pkg::CMD_ALLOC, from, 9'($urandom_range(8)),
                         8'($urandom_range(255, 1)));
            end else if (pick < 75) begin
                send_cmd(cnfa_pkg::CMD_FIND, from, 9'($urandom_range(256)),
                         8'($urandom_range(255)));
            end else if (pick < 83) begin
                send_cmd(cnfa_pkg::CMD_PACK, from, 9'($urandom_range(256)),
                         8'($urandom_range(255)));
            end else if (pick < 87) begin
                send_cmd(CMD_UNUSED, from, 9'($urandom_range(256)), 8'($urandom_range(255)));
            end else if (pick < 92) begin
                send_cmd(cnfa_pkg::CMD_ALLOC, from, 9'($urandom_range(256)), 8'd0);
            end else begin
                send_cmd(cnfa_pkg::CMD_FIND, from, 9'($urandom_range(sb.free_count)),
                         8'($urandom_range(255)));
            end
        end

        // Fill whatever is left, then probe the full store.
        send_cmd(cnfa_pkg::CMD_ALLOC, 8'd0, 9'd256, 8'hAA);
        send_cmd(cnfa_pkg::CMD_FIND, 8'd3, 9'd0, 8'd0);
        send_cmd(cnfa_pkg::CMD_FIND, 8'd3, 9'd1, 8'd0);
        send_cmd(cnfa_pkg::CMD_PACK, 8'd0, 9'd0, 8'd0);
        s_tvalid <= 1'b0;

        while (sb.owed_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.owed_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
